@@ hdl/sexlex_pkg.sv @@
`timescale 1ns / 1ps

package sexlex_pkg;

  localparam int LINE_W   = 20;
  localparam int COL_W    = 16;
  localparam int OFFS_W   = 24;
  localparam int NUM_W    = 31;
  localparam int KIND_W   = 3;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 120;

  localparam logic [LINE_W-1:0] LINE_MAX = '1;
  localparam logic [COL_W-1:0]  COL_MAX  = '1;
  localparam logic [NUM_W-1:0]  NUM_MAX  = '1;
  localparam logic [3:0]        DEC_BASE = 4'd10;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_STR  = 3'd1,
    MODE_CMT  = 3'd2,
    MODE_NUM  = 3'd3,
    MODE_SYM  = 3'd4
  } lex_mode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_LPAREN  = 3'd0,
    KIND_RPAREN  = 3'd1,
    KIND_STRING  = 3'd2,
    KIND_NUMBER  = 3'd3,
    KIND_SYMBOL  = 3'd4,
    KIND_UNKNOWN = 3'd5
  } token_kind_t;

  typedef struct packed {
    token_kind_t          kind;
    logic [LINE_W-1:0]    line;
    logic [COL_W-1:0]     column;
    logic [OFFS_W-1:0]    offset;
    logic [OFFS_W-1:0]    length;
    logic [NUM_W-1:0]     value;
    logic                 overflow;
    logic                 last;
  } token_t;

endpackage

@@ hdl/sexpr_token_lexer.sv @@
`timescale 1ns / 1ps
// Streaming lexer for S-expression source text.
// Input channel (s_*): one source byte per beat in s_tdata. A beat with
// s_tlast high marks end of text: its byte is ignored, a pending number or
// symbol token is flushed, and all counters return to their start values.
// Output channel (m_*): one token per beat; m_tuser carries the token kind
// and m_tlast marks the final token caused by one input beat.
// Tokens are registered: each completed token is written into the output
// queue and is presented on the output from there.
// Throughput: one input byte per cycle while s_tready is high. A byte that
// closes a number or a symbol and is itself a token yields two output
// beats; the three-entry output queue absorbs the extra beat, and s_tready
// drops only when the queue holds more than one token.
// When the receiver stalls, tokens wait in the output queue and s_tready
// falls once the queue cannot take two more tokens.
// Reset (rst, synchronous) empties the queue and sets line 1, column 0,
// offset 0, with no token pending.
module sexpr_token_lexer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [sexlex_pkg::IN_DATA_W-1:0]    s_tdata,  // [7:0] char_byte
  input  logic                                s_tlast,  // end_of_text
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [19:0] token_line, [35:20] token_column, [59:36] text_offset,
  // [83:60] text_length, [114:84] number_value, [115] number_overflow,
  // [119:116] zero
  output logic [sexlex_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic [sexlex_pkg::KIND_W-1:0]       m_tuser,  // [2:0] token_kind
  output logic                                m_tlast   // last
);
  import sexlex_pkg::*;

  lex_mode_t           mode, mode_next;
  logic [LINE_W-1:0]   line_count;
  logic [COL_W-1:0]    column_count;
  logic [OFFS_W-1:0]   byte_offset;
  logic [OFFS_W-1:0]   start_offset;
  logic [LINE_W-1:0]   start_line;
  logic [COL_W-1:0]    start_column;
  logic [NUM_W-1:0]    number_acc, number_acc_next;
  logic                overflow_seen, overflow_seen_next;

  token_t              queue [3];
  token_t              queue_next [3];
  logic [1:0]          count, count_next;

  logic [7:0]          ch;
  logic                beat, eot, pop;
  logic                is_dig, is_alpha, is_ws;
  logic                ends_tok, fresh;
  logic                emit_a, emit_b;
  token_t              res_a, res_b;
  logic [NUM_W+3:0]    num_sum;

  assign ch   = s_tdata;
  assign eot  = s_tlast;
  assign beat = s_tvalid && s_tready;
  assign pop  = m_tvalid && m_tready;

  assign is_dig   = ch inside {[CH_0:CH_9]};
  assign is_alpha = (ch inside {[CH_LA:CH_LZ], [CH_UA:CH_UZ]}) || ch == CH_UNDER;
  assign is_ws    = ch inside {CH_SPACE, CH_TAB, CH_CR, CH_NL};

  // A number or symbol is closed by any byte that cannot continue it; that
  // byte is then classified afresh in the same cycle.
  assign ends_tok = (mode == MODE_NUM && !is_dig) ||
                    (mode == MODE_SYM && !(is_alpha || is_dig));
  assign fresh    = !eot && (mode == MODE_IDLE || ends_tok);

  assign num_sum = ({4'd0, number_acc} << 3) + ({4'd0, number_acc} << 1) +
                   {31'd0, ch[3:0]};

  // Next lexer mode.
  always_comb begin
    mode_next = mode;
    if (eot) begin
      mode_next = MODE_IDLE;
    end else if (fresh) begin
      if (ch == CH_QUOTE) begin
        mode_next = MODE_STR;
      end else if (ch == CH_HASH) begin
        mode_next = MODE_CMT;
      end else if (is_dig) begin
        mode_next = MODE_NUM;
      end else if (is_alpha) begin
        mode_next = MODE_SYM;
      end else begin
        mode_next = MODE_IDLE;
      end
    end else begin
      case (mode)
        MODE_STR: if (ch == CH_QUOTE) mode_next = MODE_IDLE;
        MODE_CMT: if (ch == CH_NL) mode_next = MODE_IDLE;
        default:  mode_next = mode;
      endcase
    end
  end

  // Token outputs: a closing token (res_a) and a fresh single-byte token (res_b).
  always_comb begin
    emit_a = 1'b0;
    res_a  = '0;
    res_a.line   = start_line;
    res_a.column = start_column;
    res_a.offset = start_offset;
    case (mode)
      MODE_NUM: begin
        emit_a         = eot || !is_dig;
        res_a.kind     = KIND_NUMBER;
        res_a.value    = number_acc;
        res_a.overflow = overflow_seen;
      end
      MODE_SYM: begin
        emit_a       = eot || !(is_alpha || is_dig);
        res_a.kind   = KIND_SYMBOL;
        res_a.length = byte_offset - start_offset;
      end
      MODE_STR: begin
        emit_a       = !eot && ch == CH_QUOTE;
        res_a.kind   = KIND_STRING;
        res_a.length = byte_offset - start_offset;
      end
      default: emit_a = 1'b0;
    endcase

    res_b        = '0;
    res_b.line   = line_count;
    res_b.column = column_count;
    res_b.offset = byte_offset;
    res_b.last   = 1'b1;
    emit_b       = 1'b0;
    if (fresh) begin
      if (ch == CH_LPAREN) begin
        emit_b     = 1'b1;
        res_b.kind = KIND_LPAREN;
      end else if (ch == CH_RPAREN) begin
        emit_b     = 1'b1;
        res_b.kind = KIND_RPAREN;
      end else if (!(ch == CH_QUOTE || ch == CH_HASH || is_dig || is_alpha || is_ws)) begin
        emit_b     = 1'b1;
        res_b.kind = KIND_UNKNOWN;
      end
    end
    res_a.last = !emit_b;
  end

  // Number accumulator.
  always_comb begin
    number_acc_next    = number_acc;
    overflow_seen_next = overflow_seen;
    if (eot) begin
      number_acc_next    = '0;
      overflow_seen_next = 1'b0;
    end else if (fresh && is_dig) begin
      number_acc_next    = {27'd0, ch[3:0]};
      overflow_seen_next = 1'b0;
    end else if (mode == MODE_NUM && is_dig) begin
      if (num_sum > {4'd0, NUM_MAX}) begin
        number_acc_next    = NUM_MAX;
        overflow_seen_next = 1'b1;
      end else begin
        number_acc_next = num_sum[NUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (beat && eot)) begin
      mode          <= MODE_IDLE;
      line_count    <= LINE_W'(1);
      column_count  <= '0;
      byte_offset   <= '0;
      start_offset  <= '0;
      start_line    <= LINE_W'(1);
      start_column  <= '0;
      number_acc    <= '0;
      overflow_seen <= 1'b0;
    end else if (beat) begin
      mode          <= mode_next;
      number_acc    <= number_acc_next;
      overflow_seen <= overflow_seen_next;
      byte_offset   <= byte_offset + OFFS_W'(1);
      if (ch == CH_NL) begin
        if (line_count != LINE_MAX) line_count <= line_count + LINE_W'(1);
        column_count <= '0;
      end else if (column_count != COL_MAX) begin
        column_count <= column_count + COL_W'(1);
      end
      if (fresh) begin
        start_line   <= line_count;
        start_column <= column_count;
        start_offset <= (ch == CH_QUOTE) ? byte_offset + OFFS_W'(1) : byte_offset;
      end
    end
  end

  // Output queue: head in entry 0, shifts down on each output beat.
  always_comb begin
    logic [1:0] wr;
    wr         = count;
    queue_next = queue;
    if (pop) begin
      queue_next[0] = queue[1];
      queue_next[1] = queue[2];
      wr = count - 2'd1;
    end
    if (beat && (emit_a || emit_b)) begin
      queue_next[wr] = emit_a ? res_a : res_b;
      wr = wr + 2'd1;
      if (emit_a && emit_b) begin
        queue_next[wr] = res_b;
        wr = wr + 2'd1;
      end
    end
    count_next = wr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
    queue <= queue_next;
  end

  assign s_tready = count <= 2'd1;
  assign m_tvalid = count != 2'd0;
  assign m_tuser  = queue[0].kind;
  assign m_tlast  = queue[0].last;
  assign m_tdata  = {4'd0, queue[0].overflow, queue[0].value, queue[0].length,
                     queue[0].offset, queue[0].column, queue[0].line};

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output queue not empty after reset");

  a_comment_silent: assert property (@(posedge clk) disable iff (rst)
    (beat && !eot && mode == MODE_CMT) |-> !(emit_a || emit_b))
    else $error("token emitted inside a comment");

  a_flush_last: assert property (@(posedge clk) disable iff (rst)
    (beat && eot && (mode == MODE_NUM || mode == MODE_SYM)) |=>
      (count == $past(count_next) && queue[count - 2'd1].last))
    else $error("end of text did not flush the pending token as last");

  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    line_count != '0)
    else $error("line counter reached zero");

endmodule
